[hw/rtl/cbss_pkg.sv]
package cbss_pkg;

    localparam int COORD_BITS       = 16;
    localparam int TAN_BITS         = COORD_BITS + 3;
    localparam int SUB_BITS         = 6;
    localparam int MAX_SUBDIVISIONS = 63;
    localparam int SUBDIV_RESET     = 32;

    // numerator magnitude stays below 2^33 (|pos num| <= 63^3 * 2^15)
    localparam int NUM_W  = COORD_BITS + 19;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DIVS_W = 3 * SUB_BITS;
    localparam int MA_W   = 3 * SUB_BITS + 3;
    localparam int MB_W   = COORD_BITS + 2;
    localparam int PROD_W = MA_W + MB_W;

    localparam int IN_W  = 8 * COORD_BITS;
    localparam int OUT_W = ((2 * COORD_BITS + 2 * TAN_BITS + SUB_BITS + 7) / 8) * 8;

    // step numbers inside the weight and multiply-accumulate phases
    localparam logic [3:0] MAC_AXIS_Y = 4'd7;
    localparam logic [3:0] MAC_LAST   = 4'd13;
    localparam logic [3:0] WGT_LAST   = 4'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NPOW,
        S_WGT,
        S_MAC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[hw/rtl/cubic_bezier_segment_sampler_top.sv]
// Cubic Bezier segment sampler.
// Slave stream: one word carries the four control points (p0_x, p0_y, ... p3_y,
// 16 bits each, p0_x lowest). Master stream: N+1 sample words per segment, for
// t = i/N, with position and derivative truncated toward zero; tlast marks i = N.
// N comes from the subdivisions register (write enable + data; 0 reads as 1).
// Write it only while the block is idle; the block itself does not enforce it.
// All arithmetic runs through one shared 21x18 multiplier and one bit-serial
// restoring divider under a small sequencer; the block takes no new segment
// until the last sample word has left.
// Per sample: 7 weight multiplies, 14 multiply-accumulates, 4 divisions (a load
// step and 34 quotient bits each) and an output step; each segment first forms
// N^2 and N^3 on the multiplier. The divider yields one quotient bit per cycle.
// A stalled receiver holds the sample word in the output register and the
// sequencer waits. Reset (synchronous, active low) returns to idle and sets
// subdivisions to 32.
module cubic_bezier_segment_sampler_top
    import cbss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [SUB_BITS-1:0] i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pos_x, pos_y, tan_x, tan_y, sample_index, zero pad
    output logic [OUT_W-1:0]    m_axis_tdata,
    output logic                m_axis_tlast
);

    t_state r_state, n_state;

    logic [SUB_BITS-1:0]   r_subdiv;
    logic [SUB_BITS-1:0]   r_n, n_n, r_i, n_i;
    logic [3:0]            r_step, n_step;
    logic [1:0]            r_sel, n_sel;
    logic [5:0]            r_cnt, n_cnt;
    logic signed [COORD_BITS-1:0] r_pts [8];
    logic [2*SUB_BITS-1:0] r_n2, n_n2, r_a2, n_a2, r_b2, n_b2, r_ab, n_ab;
    logic [DIVS_W-1:0]     r_n3, n_n3, r_w0, n_w0, r_w1, n_w1, r_w2, n_w2, r_w3, n_w3;
    logic signed [NUM_W-1:0] r_acc, n_acc;
    logic signed [NUM_W-1:0] r_num [4];
    logic [MAG_W-1:0]      r_dq, n_dq;
    logic [DIVS_W-1:0]     r_rem, n_rem;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [TAN_BITS-1:0]   r_tx, r_ty;
    logic [SUB_BITS-1:0]   r_idx;
    logic                  r_last;

    logic [SUB_BITS-1:0]   a_val;
    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic [3:0]            mstep;
    logic                  axis_y;
    logic signed [COORD_BITS-1:0] c0, c1, c2, c3;
    logic [DIVS_W-1:0]     divisor;
    logic [DIVS_W:0]       trial;
    logic signed [NUM_W-1:0] cur_num;
    logic [MAG_W-1:0]      q_fin;
    logic signed [NUM_W-1:0] q_signed;

    function automatic logic signed [MA_W-1:0] mul3(input logic [DIVS_W-1:0] v);
        mul3 = $signed({3'b000, v}) + $signed({2'b00, v, 1'b0});
    endfunction

    assign a_val = r_n - r_i;

    assign axis_y = (r_step >= MAC_AXIS_Y);
    assign mstep  = axis_y ? (r_step - MAC_AXIS_Y) : r_step;
    assign c0 = r_pts[{2'd0, axis_y}];
    assign c1 = r_pts[{2'd1, axis_y}];
    assign c2 = r_pts[{2'd2, axis_y}];
    assign c3 = r_pts[{2'd3, axis_y}];

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            S_NPOW: begin
                op_a = $signed({{(MA_W-2*SUB_BITS){1'b0}}, (r_step[0] ? r_n2 : {6'd0, r_n})});
                op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, r_n});
            end
            S_WGT: begin
                case (r_step)
                    4'd0: begin
                        op_a = $signed({{(MA_W-SUB_BITS){1'b0}}, a_val});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, a_val});
                    end
                    4'd1: begin
                        op_a = $signed({{(MA_W-SUB_BITS){1'b0}}, r_i});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, r_i});
                    end
                    4'd2: begin
                        op_a = $signed({{(MA_W-SUB_BITS){1'b0}}, a_val});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, r_i});
                    end
                    4'd3: begin
                        op_a = $signed({{(MA_W-2*SUB_BITS){1'b0}}, r_a2});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, a_val});
                    end
                    4'd4: begin
                        op_a = $signed({{(MA_W-2*SUB_BITS){1'b0}}, r_a2});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, r_i});
                    end
                    4'd5: begin
                        op_a = $signed({{(MA_W-2*SUB_BITS){1'b0}}, r_b2});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, a_val});
                    end
                    default: begin
                        op_a = $signed({{(MA_W-2*SUB_BITS){1'b0}}, r_b2});
                        op_b = $signed({{(MB_W-SUB_BITS){1'b0}}, r_i});
                    end
                endcase
            end
            S_MAC: begin
                case (mstep)
                    4'd0: begin
                        op_a = $signed({3'b000, r_w0});
                        op_b = MB_W'(c0);
                    end
                    4'd1: begin
                        op_a = mul3(r_w1);
                        op_b = MB_W'(c1);
                    end
                    4'd2: begin
                        op_a = mul3(r_w2);
                        op_b = MB_W'(c2);
                    end
                    4'd3: begin
                        op_a = $signed({3'b000, r_w3});
                        op_b = MB_W'(c3);
                    end
                    4'd4: begin
                        op_a = mul3({6'd0, r_a2});
                        op_b = MB_W'(c1) - MB_W'(c0);
                    end
                    4'd5: begin
                        op_a = mul3({5'd0, r_ab, 1'b0});
                        op_b = MB_W'(c2) - MB_W'(c1);
                    end
                    default: begin
                        op_a = mul3({6'd0, r_b2});
                        op_b = MB_W'(c3) - MB_W'(c2);
                    end
                endcase
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    // divider datapath
    assign cur_num = r_num[r_sel];
    assign divisor = r_sel[0] ? {6'd0, r_n2} : r_n3;
    assign trial   = {r_rem, r_dq[MAG_W-1]};
    assign q_fin   = n_dq;
    assign q_signed = cur_num[NUM_W-1] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_NPOW;
            S_NPOW: if (r_step[0]) n_state = S_WGT;
            S_WGT:  if (r_step == WGT_LAST) n_state = S_MAC;
            S_MAC:  if (r_step == MAC_LAST) n_state = S_DIV;
            S_DIV:  if (r_step[0] && r_cnt == 6'(MAG_W - 1) && r_sel == 2'd3) n_state = S_OUT;
            S_OUT: begin
                if (m_axis_tready) n_state = r_last ? S_IDLE : S_WGT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_n = r_n;   n_i = r_i;   n_step = r_step; n_sel = r_sel; n_cnt = r_cnt;
        n_n2 = r_n2; n_n3 = r_n3; n_a2 = r_a2; n_b2 = r_b2; n_ab = r_ab;
        n_w0 = r_w0; n_w1 = r_w1; n_w2 = r_w2; n_w3 = r_w3;
        n_acc = r_acc; n_dq = r_dq; n_rem = r_rem;
        case (r_state)
            S_IDLE: begin
                if (r_subdiv == '0)
                    n_n = SUB_BITS'(1);
                else if (r_subdiv > SUB_BITS'(MAX_SUBDIVISIONS))
                    n_n = SUB_BITS'(MAX_SUBDIVISIONS);
                else
                    n_n = r_subdiv;
                n_i = '0;
                n_step = '0;
            end
            S_NPOW: begin
                if (r_step[0]) begin
                    n_n3 = prod[DIVS_W-1:0];
                    n_step = '0;
                end else begin
                    n_n2 = prod[2*SUB_BITS-1:0];
                    n_step = 4'd1;
                end
            end
            S_WGT: begin
                case (r_step)
                    4'd0: n_a2 = prod[2*SUB_BITS-1:0];
                    4'd1: n_b2 = prod[2*SUB_BITS-1:0];
                    4'd2: n_ab = prod[2*SUB_BITS-1:0];
                    4'd3: n_w0 = prod[DIVS_W-1:0];
                    4'd4: n_w1 = prod[DIVS_W-1:0];
                    4'd5: n_w2 = prod[DIVS_W-1:0];
                    default: n_w3 = prod[DIVS_W-1:0];
                endcase
                n_step = (r_step == WGT_LAST) ? 4'd0 : r_step + 4'd1;
            end
            S_MAC: begin
                if (mstep == 4'd0 || mstep == 4'd4)
                    n_acc = prod[NUM_W-1:0];
                else
                    n_acc = r_acc + prod[NUM_W-1:0];
                n_step = (r_step == MAC_LAST) ? 4'd0 : r_step + 4'd1;
                n_sel = '0;
            end
            S_DIV: begin
                if (!r_step[0]) begin
                    n_dq  = cur_num[NUM_W-1] ? MAG_W'(-cur_num) : MAG_W'(cur_num);
                    n_rem = '0;
                    n_cnt = '0;
                    n_step = 4'd1;
                end else begin
                    if (trial >= {1'b0, divisor}) begin
                        n_rem = DIVS_W'(trial - {1'b0, divisor});
                        n_dq  = {r_dq[MAG_W-2:0], 1'b1};
                    end else begin
                        n_rem = trial[DIVS_W-1:0];
                        n_dq  = {r_dq[MAG_W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(MAG_W - 1)) begin
                        n_step = '0;
                        n_sel = r_sel + 2'd1;
                    end
                end
            end
            S_OUT: begin
                n_step = '0;
                if (m_axis_tready && !r_last) n_i = r_i + SUB_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_subdiv <= SUB_BITS'(SUBDIV_RESET);
            r_step   <= '0;
            r_sel    <= '0;
            r_cnt    <= '0;
            r_i      <= '0;
            r_n      <= SUB_BITS'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_subdiv <= i_cfg_wr_data;
            r_step <= n_step;
            r_sel  <= n_sel;
            r_cnt  <= n_cnt;
            r_i    <= n_i;
            r_n    <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n2 <= n_n2; r_n3 <= n_n3;
        r_a2 <= n_a2; r_b2 <= n_b2; r_ab <= n_ab;
        r_w0 <= n_w0; r_w1 <= n_w1; r_w2 <= n_w2; r_w3 <= n_w3;
        r_acc <= n_acc; r_dq <= n_dq; r_rem <= n_rem;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            for (int k = 0; k < 8; k++)
                r_pts[k] <= s_axis_tdata[k*COORD_BITS +: COORD_BITS];
        end
        if (r_state == S_MAC) begin
            if (r_step == 4'd3)  r_num[0] <= n_acc;
            if (r_step == 4'd6)  r_num[1] <= n_acc;
            if (r_step == 4'd10) r_num[2] <= n_acc;
            if (r_step == MAC_LAST) r_num[3] <= n_acc;
        end
        if (r_state == S_DIV && r_step[0] && r_cnt == 6'(MAG_W - 1)) begin
            case (r_sel)
                2'd0: r_px <= q_signed[COORD_BITS-1:0];
                2'd1: r_tx <= q_signed[TAN_BITS-1:0];
                2'd2: r_py <= q_signed[COORD_BITS-1:0];
                default: r_ty <= q_signed[TAN_BITS-1:0];
            endcase
            r_idx  <= r_i;
            r_last <= (r_i == r_n);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(OUT_W-2*COORD_BITS-2*TAN_BITS-SUB_BITS){1'b0}},
                            r_idx, r_ty, r_tx, r_py, r_px};

endmodule

[dv/tb_top.sv]
module tb_top;
    import cbss_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [TAN_BITS-1:0]   tan_x;
        logic signed [TAN_BITS-1:0]   tan_y;
        logic [SUB_BITS-1:0]          idx;
        logic                         last;
    } t_sample;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [SUB_BITS-1:0] i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;

    cubic_bezier_segment_sampler_top i_dut (.*);

    logic [IN_W-1:0] seg_queue[$];
    t_sample         sample_queue[$];
    int unsigned     subdiv_now;
    int              errors;
    int              samples_seen;
    int              segs_sent;
    longint          cycles;
    int              src_wait;
    int              snk_wait;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd30000000) begin
            $display("cubic_bezier_segment_sampler_top test failed");
            $finish;
        end
    end

    function automatic longint trunc_div(longint num, longint den);
        longint q;
        q = (num < 0 ? -num : num) / den;
        return (num < 0) ? -q : q;
    endfunction

    // expand one segment into its N+1 curve samples
    function automatic void predict_samples(logic [IN_W-1:0] w);
        longint cx[4], cy[4], n, a, b, px, py, tx, ty;
        t_sample s;
        for (int k = 0; k < 4; k++) begin
            cx[k] = longint'($signed(w[32*k +: 16]));
            cy[k] = longint'($signed(w[32*k+16 +: 16]));
        end
        n = (subdiv_now == 0) ? 1 : subdiv_now;
        for (int i = 0; i <= n; i++) begin
            a = n - i;
            b = i;
            px = a*a*a*cx[0] + 3*b*a*a*cx[1] + 3*b*b*a*cx[2] + b*b*b*cx[3];
            py = a*a*a*cy[0] + 3*b*a*a*cy[1] + 3*b*b*a*cy[2] + b*b*b*cy[3];
            tx = 3*(a*a*(cx[1]-cx[0]) + 2*b*a*(cx[2]-cx[1]) + b*b*(cx[3]-cx[2]));
            ty = 3*(a*a*(cy[1]-cy[0]) + 2*b*a*(cy[2]-cy[1]) + b*b*(cy[3]-cy[2]));
            s.pos_x = COORD_BITS'(trunc_div(px, n*n*n));
            s.pos_y = COORD_BITS'(trunc_div(py, n*n*n));
            s.tan_x = TAN_BITS'(trunc_div(tx, n*n));
            s.tan_y = TAN_BITS'(trunc_div(ty, n*n));
            s.idx   = SUB_BITS'(i);
            s.last  = (i == n);
            sample_queue.push_back(s);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait      <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else begin
            if (s_axis_tvalid) begin
                predict_samples(s_axis_tdata);
                segs_sent <= segs_sent + 1;
            end
            if (src_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                src_wait      <= src_wait - 1;
            end else if (seg_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= seg_queue.pop_front();
                src_wait      <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sample got, want;
        int      nerr;
        nerr = 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[50:32],
                        m_axis_tdata[69:51], m_axis_tdata[75:70], m_axis_tlast};
                samples_seen <= samples_seen + 1;
                if (sample_queue.size() == 0) begin
                    $error("unexpected sample word");
                    nerr++;
                end else begin
                    want = sample_queue.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $error("pos_x exp %0d got %0d", want.pos_x, got.pos_x);
                        nerr++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("pos_y exp %0d got %0d", want.pos_y, got.pos_y);
                        nerr++;
                    end
                    if (got.tan_x !== want.tan_x) begin
                        $error("tan_x exp %0d got %0d", want.tan_x, got.tan_x);
                        nerr++;
                    end
                    if (got.tan_y !== want.tan_y) begin
                        $error("tan_y exp %0d got %0d", want.tan_y, got.tan_y);
                        nerr++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("sample_index exp %0d got %0d", want.idx, got.idx);
                        nerr++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_sample exp %0d got %0d", want.last, got.last);
                        nerr++;
                    end
                end
                errors <= errors + nerr;
            end
            if (snk_wait > 0) begin
                m_axis_tready <= 1'b0;
                snk_wait      <= snk_wait - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid)
                    snk_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
        end
    end

    function automatic logic [IN_W-1:0] rand_seg();
        logic [IN_W-1:0] w;
        for (int k = 0; k < 4; k++)
            w[32*k +: 32] = $urandom;
        return w;
    endfunction

    function automatic logic [IN_W-1:0] fill_seg(logic [15:0] v);
        return {8{v}};
    endfunction

    // run one phase at a given subdivision count and wait for it to drain
    task automatic run_phase(int unsigned n, int num_rand, bit directed);
        int target;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= SUB_BITS'(n);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        subdiv_now = n;
        target = segs_sent;
        if (directed) begin
            seg_queue.push_back(fill_seg(16'h7fff));
            seg_queue.push_back(fill_seg(16'h8000));
            seg_queue.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                                 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
            seg_queue.push_back({16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                 16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
            seg_queue.push_back(fill_seg(16'h0000));
            seg_queue.push_back(fill_seg(16'hffff));
            target += 6;
        end
        for (int k = 0; k < num_rand; k++)
            seg_queue.push_back(rand_seg());
        target += num_rand;
        while (segs_sent < target || sample_queue.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors = 0; samples_seen = 0; segs_sent = 0; cycles = 0;
        src_wait = 0; snk_wait = 0;
        subdiv_now = SUBDIV_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset value first, then zero (treated as one), extremes, and a few others
        run_phase(SUBDIV_RESET, 0, 0);
        seg_queue.push_back(rand_seg());
        begin
            int t;
            t = segs_sent + 1;
            while (segs_sent < t || sample_queue.size() > 0) @(posedge i_clk);
            repeat (200) @(posedge i_clk);
        end
        run_phase(0, 20, 1);
        run_phase(1, 30, 1);
        run_phase(63, 8, 1);
        run_phase(2, 30, 0);
        run_phase(5, 25, 0);
        run_phase(17, 15, 0);
        run_phase(3, 20, 0);
        $display("covered %0d segments, %0d samples, subdivisions 0,1,2,3,5,17,32,63",
                 segs_sent, samples_seen);
        if (errors == 0)
            $display("cubic_bezier_segment_sampler_top test passed");
        else
            $display("cubic_bezier_segment_sampler_top test failed");
        $finish;
    end

endmodule
